[rtl/pwsm_pkg.sv]
package pwsm_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int WIDE_W     = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
    localparam int SUM_W      = WIDE_W + 1;
    localparam int NUM_W      = 40;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
    localparam int SPEED_W    = 13;
    localparam int ROUND_W    = 16;
    localparam int RECIP_W    = 17;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;
    localparam logic [ROUND_W-1:0] ROUND_MAX = 16'hFFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_MAX_PULSES     = 3'd0;
    localparam logic [2:0] REG_MAX_TIME       = 3'd1;
    localparam logic [2:0] REG_MIN_TIME       = 3'd2;
    localparam logic [2:0] REG_MISS_LIMIT     = 3'd3;
    localparam logic [2:0] REG_DISTANCE_SCALE = 3'd4;

    localparam logic [7:0]  RST_MAX_PULSES     = 8'd50;
    localparam logic [31:0] RST_MAX_TIME       = 32'd3000000;
    localparam logic [31:0] RST_MIN_TIME       = 32'd2;
    localparam logic [7:0]  RST_MISS_LIMIT     = 8'd5;
    localparam logic [31:0] RST_DISTANCE_SCALE = 32'd11869200;

    typedef struct packed {
        logic [7:0]  max_pulses;
        logic [31:0] max_time;
        logic [31:0] min_time;
        logic [7:0]  miss_limit;
        logic [31:0] distance_scale;
    } cfg_t;

    typedef enum logic [1:0] {
        ITEM_CAPTURE,
        ITEM_IGNORE,
        ITEM_POLL
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [31:0] period_ticks;
    } item_t;

    typedef struct packed {
        logic               speed_updated;
        logic               window_closed;
        logic [31:0]        total_pulses;
        logic [SPEED_W-1:0] speed_value;
    } result_t;

endpackage

[rtl/pwsm_regs.sv]
module pwsm_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [pwsm_pkg::DATA_W-1:0]   pwdata,
    output logic [pwsm_pkg::DATA_W-1:0]   prdata,
    output pwsm_pkg::cfg_t                cfg
);
    import pwsm_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_pulses     <= RST_MAX_PULSES;
            cfg_reg.max_time       <= RST_MAX_TIME;
            cfg_reg.min_time       <= RST_MIN_TIME;
            cfg_reg.miss_limit     <= RST_MISS_LIMIT;
            cfg_reg.distance_scale <= RST_DISTANCE_SCALE;
        end
        else if (wr_en)
        begin
            case (index)
                REG_MAX_PULSES:     cfg_reg.max_pulses     <= pwdata[7:0];
                REG_MAX_TIME:       cfg_reg.max_time       <= pwdata;
                REG_MIN_TIME:       cfg_reg.min_time       <= pwdata;
                REG_MISS_LIMIT:     cfg_reg.miss_limit     <= pwdata[7:0];
                REG_DISTANCE_SCALE: cfg_reg.distance_scale <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_MAX_PULSES:     prdata = {24'd0, cfg_reg.max_pulses};
            REG_MAX_TIME:       prdata = cfg_reg.max_time;
            REG_MIN_TIME:       prdata = cfg_reg.min_time;
            REG_MISS_LIMIT:     prdata = {24'd0, cfg_reg.miss_limit};
            REG_DISTANCE_SCALE: prdata = cfg_reg.distance_scale;
            default:            prdata = '0;
        endcase
    end

endmodule

[rtl/pwsm_front.sv]
module pwsm_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_poll,
    input  logic [31:0]     in_period,
    input  logic            in_pin_high,
    output logic            q_valid,
    output pwsm_pkg::item_t q_item,
    input  logic            q_pop
);
    import pwsm_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    item_t             item;
    logic              push;

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        item.period_ticks = in_period;
        if (in_poll)
            item.kind = ITEM_POLL;
        else if (in_pin_high)
            item.kind = ITEM_IGNORE;
        else
            item.kind = ITEM_CAPTURE;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !q_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && q_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[rtl/pwsm_div.sv]
module pwsm_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pwsm_pkg::NUM_W-1:0]      dividend,
    input  logic [pwsm_pkg::TIME_WIDTH-1:0] divisor,
    output logic                            done,
    output logic [pwsm_pkg::NUM_W-1:0]      quotient,
    output logic [pwsm_pkg::TIME_WIDTH-1:0] remainder
);
    import pwsm_pkg::*;

    logic [NUM_W-1:0]      quo_reg;
    logic [TIME_WIDTH-1:0] rem_reg;
    logic [TIME_WIDTH-1:0] den_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [TIME_WIDTH:0]   trial;
    logic                  fits;

    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign fits      = (trial >= {1'b0, den_reg});
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            if (fits)
                rem_reg <= TIME_WIDTH'(trial - {1'b0, den_reg});
            else
                rem_reg <= trial[TIME_WIDTH-1:0];
        end
    end

endmodule

[rtl/pwsm_back.sv]
module pwsm_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  pwsm_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  pwsm_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output pwsm_pkg::result_t out_result
);
    import pwsm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_SCALE
    } state_t;

    localparam logic [SUM_W-1:0] TIME_TOP =
        {{(SUM_W - TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};

    state_t                state_reg;
    logic [TIME_WIDTH-1:0] time_sum_reg;
    logic [7:0]            window_count_reg;
    logic [TIME_WIDTH-1:0] latched_time_reg;
    logic [7:0]            latched_pulses_reg;
    logic                  pending_reg;
    logic [31:0]           pulse_total_reg;
    logic [7:0]            miss_count_reg;
    logic [SPEED_W-1:0]    speed_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [ROUND_W-1:0]    round_reg;
    logic                  out_valid_reg;
    result_t               out_result_reg;

    logic [SUM_W-1:0]            ts_sum;
    logic [TIME_WIDTH-1:0]       ts_new;
    logic [7:0]                  wc_new;
    logic [31:0]                 total_new;
    logic                        close;
    logic                        time_ok;
    logic                        miss_over;
    logic [NUM_W-1:0]            product;
    logic                        div_start;
    logic                        div_done;
    logic [NUM_W-1:0]            div_q;
    logic [TIME_WIDTH-1:0]       div_r;
    logic                        round_up;
    logic                        round_sat;
    logic [ROUND_W-1:0]          rounded;
    logic [ROUND_W+RECIP_W-1:0]  scaled_full;
    logic [SPEED_W-1:0]          scaled;
    logic                        is_capture;
    logic                        is_poll;
    logic                        go_div;
    logic                        miss_zero;
    logic [31:0]                 rep_total;
    logic                        rep_closed;

    assign ts_sum    = SUM_W'(time_sum_reg) + SUM_W'(q_item.period_ticks);
    assign ts_new    = (ts_sum > TIME_TOP) ? {TIME_WIDTH{1'b1}} : ts_sum[TIME_WIDTH-1:0];
    assign wc_new    = window_count_reg + 8'd1;
    assign total_new = pulse_total_reg + 32'd1;
    assign close     = (wc_new == cfg.max_pulses)
                       || (WIDE_W'(ts_new) > WIDE_W'(cfg.max_time));
    assign time_ok   = WIDE_W'(latched_time_reg) > WIDE_W'(cfg.min_time);
    assign miss_over = miss_count_reg > cfg.miss_limit;
    assign product   = NUM_W'(latched_pulses_reg) * NUM_W'(cfg.distance_scale);
    assign div_start = (state_reg == ST_START);

    assign is_capture = (q_item.kind == ITEM_CAPTURE);
    assign is_poll    = (q_item.kind == ITEM_POLL);
    assign go_div     = is_poll && pending_reg && time_ok;
    assign miss_zero  = is_poll && !pending_reg && miss_over;
    assign rep_total  = is_capture ? total_new : pulse_total_reg;
    assign rep_closed = is_capture && close;

    assign q_pop = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || out_ready);

    assign round_up  = div_r > (latched_time_reg >> 1);
    assign round_sat = (div_q[NUM_W-1:ROUND_W] != '0)
                       || (round_up && div_q[ROUND_W-1:0] == ROUND_MAX);
    assign rounded   = round_sat ? ROUND_MAX : div_q[ROUND_W-1:0] + ROUND_W'(round_up);

    assign scaled_full = round_reg * RECIP_TEN;
    assign scaled      = scaled_full[RECIP_SHIFT +: SPEED_W];

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    pwsm_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (num_reg),
        .divisor   (latched_time_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            time_sum_reg       <= '0;
            window_count_reg   <= '0;
            latched_time_reg   <= '0;
            latched_pulses_reg <= '0;
            pending_reg        <= 1'b0;
            pulse_total_reg    <= '0;
            miss_count_reg     <= '0;
            speed_reg          <= '0;
            num_reg            <= '0;
            round_reg          <= '0;
            out_valid_reg      <= 1'b0;
            out_result_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        out_result_reg.speed_value   <= miss_zero ? '0 : speed_reg;
                        out_result_reg.total_pulses  <= rep_total;
                        out_result_reg.window_closed <= rep_closed;
                        out_result_reg.speed_updated <= miss_zero;
                        out_valid_reg                <= !go_div;
                        case (q_item.kind)
                            ITEM_CAPTURE:
                            begin
                                pulse_total_reg <= total_new;
                                if (close)
                                begin
                                    latched_time_reg   <= ts_new;
                                    latched_pulses_reg <= wc_new;
                                    time_sum_reg       <= '0;
                                    window_count_reg   <= '0;
                                    pending_reg        <= 1'b1;
                                end
                                else
                                begin
                                    time_sum_reg     <= ts_new;
                                    window_count_reg <= wc_new;
                                end
                            end
                            ITEM_POLL:
                            begin
                                if (pending_reg)
                                begin
                                    pending_reg    <= 1'b0;
                                    miss_count_reg <= '0;
                                    if (time_ok)
                                    begin
                                        num_reg   <= product;
                                        state_reg <= ST_START;
                                    end
                                end
                                else
                                begin
                                    if (miss_count_reg != 8'hFF)
                                        miss_count_reg <= miss_count_reg + 8'd1;
                                    if (miss_over)
                                        speed_reg <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    else if (out_ready)
                        out_valid_reg <= 1'b0;
                end
                ST_START:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        round_reg <= rounded;
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    speed_reg                    <= scaled;
                    out_result_reg.speed_value   <= scaled;
                    out_result_reg.total_pulses  <= pulse_total_reg;
                    out_result_reg.window_closed <= 1'b0;
                    out_result_reg.speed_updated <= 1'b1;
                    out_valid_reg                <= 1'b1;
                    state_reg                    <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[rtl/pulse_window_speed_meter_top.sv]
// Wheel-speed meter. Capture words carry a pulse period and the pin level; poll words
// turn the last closed measuring window into a speed. Every input word gives exactly one
// result word. Input words enter a two-word queue, so the slave side keeps taking words
// while a result waits on the master side, until the queue is full. Captures, ignored
// captures and polls that do not compute a speed are finished in the idle state as they
// leave the queue. A poll that computes a speed goes through these steps after it leaves
// the queue: the multiply, the start of the 40-step serial divider (one quotient bit per
// cycle), its 40 steps, rounding and the divide-by-ten; the queue stalls meanwhile.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16; the
// user must write them only while no word is in flight, which the block does not enforce.
module pulse_window_speed_meter_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [39:0]                 s_tdata,  // period_ticks[31:0], pin_high[32], zero pad
    input  logic                        s_tuser,  // operation
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [47:0]                 m_tdata,  // speed_value[12:0], total_pulses[44:13],
                                                  // window_closed[45], speed_updated[46], pad
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwsm_pkg::ADDR_W-1:0] paddr,
    input  logic [pwsm_pkg::DATA_W-1:0] pwdata,
    output logic [pwsm_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import pwsm_pkg::*;

    cfg_t    cfg;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t result;

    assign pready  = 1'b1;
    assign m_tdata = {1'b0, result};

    pwsm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pwsm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_poll     (s_tuser),
        .in_period   (s_tdata[31:0]),
        .in_pin_high (s_tdata[32]),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    pwsm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

endmodule

[rtl/pwsm_checker.sv]
module pwsm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        pready
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[12:0] <= 13'd6553)
        else $error("speed above saturated range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[45] && m_tdata[46]))
        else $error("window close and speed update in one word");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !s_tvalid && !$past(s_tvalid) |=> s_tready)
        else $error("queue full with no words arriving");

    assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind pulse_window_speed_meter_top pwsm_checker u_pwsm_checker (.*);
